// ===== rtl/core/wdc_pkg.sv =====
// wdc_pkg: shared types, codes and constants of the wall distance conditioner
// no dependencies; used by every module under rtl/core but wdc_fifo
package wdc_pkg;

  // default values of the top level parameters
  localparam int POSITIONS_DEF  = 4;
  localparam int IR_MIN_MM_DEF  = 20;
  localparam int IR_MAX_MM_DEF  = 150;
  localparam int TOF_MIN_MM_DEF = 5;
  localparam int TOF_MAX_MM_DEF = 200;
  localparam int ADC_BITS_DEF   = 12;

  localparam int NUM_SLOTS = 4;
  localparam int IR_GUARD  = 10;
  localparam logic [10:0] DIST_MAX = 11'd2047;

  // reset values of the registers
  localparam logic [10:0] SIDE_THR_RST  = 11'd90;
  localparam logic [10:0] FRONT_THR_RST = 11'd100;
  localparam logic [19:0] IR_GAIN_RST   = 20'd50000;
  localparam logic [11:0] IR_BASE_RST   = 12'd100;

  // register indexes
  localparam logic [2:0] REG_OFFSET_LEFT        = 3'd0;
  localparam logic [2:0] REG_OFFSET_FRONT_LEFT  = 3'd1;
  localparam logic [2:0] REG_OFFSET_FRONT_RIGHT = 3'd2;
  localparam logic [2:0] REG_OFFSET_RIGHT       = 3'd3;
  localparam logic [2:0] REG_SIDE_THRESHOLD     = 3'd4;
  localparam logic [2:0] REG_FRONT_THRESHOLD    = 3'd5;
  localparam logic [2:0] REG_IR_GAIN            = 3'd6;
  localparam logic [2:0] REG_IR_BASELINE        = 3'd7;

  // request action codes
  localparam logic [1:0] ACT_SAMPLE    = 2'd0;
  localparam logic [1:0] ACT_CAL_CLEAR = 2'd1;
  localparam logic [1:0] ACT_CAL_FIN   = 2'd2;

  typedef enum logic [1:0] {
    CMD_MM     = 2'd0,  // value holds a finished distance in mm
    CMD_DIV    = 2'd1,  // value holds ADC code minus baseline
    CMD_CLEAR  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [1:0]  pos;
    logic [11:0] value;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic [1:0]  slot;
    logic [10:0] distance;
    logic [3:0]  bitmap;
    logic        front;
    logic [10:0] average;
    logic        last;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic [NUM_SLOTS-1:0][10:0] offset;
    logic [10:0] side_thr;
    logic [10:0] front_thr;
    logic [19:0] ir_gain;
    logic [11:0] ir_baseline;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/core/wdc_fifo.sv =====
// wdc_fifo: small register-based first-in first-out queue
// no package dependency; used for the command and result queues
module wdc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/wdc_div.sv =====
// wdc_div: 32 by 16 bit restoring divider, one quotient bit per cycle
// depends on wdc_pkg for the request struct
module wdc_div
  import wdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [4:0]  cnt;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [31:0] quo;
  logic [16:0] rem_sh;
  logic        fits;

  assign rem_sh   = {rem[15:0], quo[31]};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[30:0], fits};
    end
  end

endmodule

// ===== rtl/core/wdc_front.sv =====
// wdc_front: accepts requests, drops ignored ones, clamps range samples
// and turns IR samples into a distance or a division command; uses wdc_pkg
module wdc_front
  import wdc_pkg::*;
#(
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int IR_MAX_MM  = IR_MAX_MM_DEF,
  parameter int TOF_MIN_MM = TOF_MIN_MM_DEF,
  parameter int TOF_MAX_MM = TOF_MAX_MM_DEF,
  parameter int ADC_BITS   = ADC_BITS_DEF
) (
  input  logic        accept,
  input  logic [1:0]  action,
  input  logic [1:0]  position,
  input  logic        sensor_kind,
  input  logic [11:0] raw_reading,
  input  logic [11:0] ir_baseline,
  output logic        cmd_push,
  output cmd_t        cmd
);

  localparam int NSLOT = (POSITIONS < NUM_SLOTS) ? POSITIONS : NUM_SLOTS;

  logic [11:0] adc_mask;
  logic [11:0] code;
  logic [12:0] guard;
  logic        keep;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      adc_mask[i] = (i < ADC_BITS);
    end
    code  = raw_reading & adc_mask;
    guard = {1'b0, ir_baseline} + 13'(IR_GUARD);
    keep  = 1'b0;
    cmd.op    = CMD_MM;
    cmd.pos   = position;
    cmd.value = '0;
    unique case (action)
      ACT_SAMPLE: begin
        keep = ({1'b0, position} < 3'(NSLOT));
        if (!sensor_kind) begin
          if (raw_reading < 12'(TOF_MIN_MM)) begin
            cmd.value = 12'(TOF_MIN_MM);
          end else if (raw_reading > 12'(TOF_MAX_MM)) begin
            cmd.value = 12'(TOF_MAX_MM);
          end else begin
            cmd.value = raw_reading;
          end
        end else if ({1'b0, code} <= guard) begin
          cmd.value = 12'(IR_MAX_MM);
        end else begin
          cmd.op    = CMD_DIV;
          cmd.value = code - ir_baseline;
        end
      end
      ACT_CAL_CLEAR: begin
        keep   = 1'b1;
        cmd.op = CMD_CLEAR;
      end
      ACT_CAL_FIN: begin
        keep   = 1'b1;
        cmd.op = CMD_FINISH;
      end
      default: keep = 1'b0;
    endcase
    cmd_push = accept && keep;
  end

endmodule

// ===== rtl/core/wdc_back.sv =====
// wdc_back: executes queued commands, holds slot and calibration state,
// shares one divider for IR conversion and averages; uses wdc_pkg, wdc_div
module wdc_back
  import wdc_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEF,
  parameter int IR_MIN_MM = IR_MIN_MM_DEF,
  parameter int IR_MAX_MM = IR_MAX_MM_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int NSLOT = (POSITIONS < NUM_SLOTS) ? POSITIONS : NUM_SLOTS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_IRDIV = 6'b000010,
    S_APPLY = 6'b000100,
    S_EMIT  = 6'b001000,
    S_FCHK  = 6'b010000,
    S_FDIV  = 6'b100000
  } state_t;

  state_t      state;
  logic [1:0]  slot;
  logic [11:0] mm;
  logic        last;
  logic        calibrating;
  logic [10:0] slot_distance [NUM_SLOTS];
  logic [31:0] cal_sum       [NUM_SLOTS];
  logic [15:0] cal_count     [NUM_SLOTS];
  logic [10:0] cal_avg       [NUM_SLOTS];

  div_req_t    div_req;
  logic        div_busy;
  logic        div_done;
  logic [31:0] quotient;

  logic [13:0] off_ext;
  logic [13:0] adj;
  logic [10:0] dist_next;
  logic [13:0] raw_val;
  logic        raw_pos;
  logic [11:0] ir_mm;
  logic [10:0] avg_next;
  logic [3:0]  bitmap;
  logic [10:0] thr;

  wdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    off_ext = {{3{cfg.offset[slot][10]}}, cfg.offset[slot]};
    adj     = {2'b00, mm} + off_ext;
    if (adj[13]) begin
      dist_next = '0;
    end else if (adj > {3'b000, DIST_MAX}) begin
      dist_next = DIST_MAX;
    end else begin
      dist_next = adj[10:0];
    end
    // offset-free value that calibration accumulates
    raw_val = {3'b000, dist_next} - off_ext;
    raw_pos = !raw_val[13] && (raw_val != '0);

    if (quotient < 32'(IR_MIN_MM)) begin
      ir_mm = 12'(IR_MIN_MM);
    end else if (quotient > 32'(IR_MAX_MM)) begin
      ir_mm = 12'(IR_MAX_MM);
    end else begin
      ir_mm = quotient[11:0];
    end
    avg_next = (quotient > {21'd0, DIST_MAX}) ? DIST_MAX : quotient[10:0];

    for (int i = 0; i < NUM_SLOTS; i++) begin
      thr = (i == 1 || i == 2) ? cfg.front_thr : cfg.side_thr;
      bitmap[i] = (i < NSLOT) && (slot_distance[i] != '0) && (slot_distance[i] < thr);
    end

    res.slot     = slot;
    res.distance = slot_distance[slot];
    res.bitmap   = bitmap;
    res.front    = bitmap[1] | bitmap[2];
    res.average  = cal_avg[slot];
    res.last     = last;
  end

  always_comb begin
    cmd_pop          = (state == S_IDLE) && !cmd_empty;
    res_push         = (state == S_EMIT) && !res_full;
    div_req.start    = 1'b0;
    div_req.dividend = {12'd0, cfg.ir_gain};
    div_req.divisor  = {4'd0, cmd.value};
    if (state == S_IDLE) begin
      div_req.start = !cmd_empty && (cmd.op == CMD_DIV);
    end else if (state == S_FCHK) begin
      div_req.start    = (cal_count[slot] != '0);
      div_req.dividend = cal_sum[slot];
      div_req.divisor  = cal_count[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      calibrating <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_distance[i] <= '0;
        cal_sum[i]       <= '0;
        cal_count[i]     <= '0;
        cal_avg[i]       <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            unique case (cmd.op)
              CMD_MM:     state <= S_APPLY;
              CMD_DIV:    state <= S_IRDIV;
              CMD_CLEAR: begin
                calibrating <= 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                  cal_sum[i]   <= '0;
                  cal_count[i] <= '0;
                end
              end
              CMD_FINISH: begin
                calibrating <= 1'b0;
                state       <= S_FCHK;
              end
            endcase
          end
        end
        S_IRDIV: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          slot_distance[slot] <= dist_next;
          if (calibrating && raw_pos && (cal_count[slot] != 16'hFFFF)) begin
            cal_sum[slot]   <= cal_sum[slot] + {19'd0, raw_val[12:0]};
            cal_count[slot] <= cal_count[slot] + 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) begin
            state <= last ? S_IDLE : S_FCHK;
          end
        end
        S_FCHK: begin
          state <= (cal_count[slot] != '0) ? S_FDIV : S_EMIT;
        end
        S_FDIV: begin
          if (div_done) begin
            cal_avg[slot] <= avg_next;
            state         <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers of the current command
  always_ff @(posedge clk) begin
    if (state == S_IDLE && !cmd_empty) begin
      slot <= (cmd.op == CMD_FINISH) ? 2'd0 : cmd.pos;
      mm   <= cmd.value;
      last <= (cmd.op != CMD_FINISH) || (NSLOT == 1);
    end else if (state == S_IRDIV && div_done) begin
      mm <= ir_mm;
    end else if (state == S_EMIT && !res_full && !last) begin
      slot <= slot + 1'b1;
      last <= ((slot + 1'b1) == 2'(NSLOT - 1));
    end
  end

endmodule

// ===== rtl/core/wall_distance_conditioner_core.sv =====
// Wall distance conditioner: requests go into a four-entry command queue, a
// sequencer works them off one at a time and results leave through a
// two-entry result queue, so pushing and popping stall independently. A range
// sample or an IR sample at or below the guard band passes through the apply
// and emit states; an IR sample that needs the conversion first waits on the
// shared 32-step radix-2 divider. A calibration clear is done in idle.
// A finish visits each slot in turn through a check state, a division for a
// slot with a nonzero count, and the emit state. Registers are written on the
// config channel, which is always ready, and should only be changed while idle.
// Depends on wdc_pkg, wdc_fifo, wdc_div, wdc_front and wdc_back.
module wall_distance_conditioner_core
  import wdc_pkg::*;
#(
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int IR_MIN_MM  = IR_MIN_MM_DEF,
  parameter int IR_MAX_MM  = IR_MAX_MM_DEF,
  parameter int TOF_MIN_MM = TOF_MIN_MM_DEF,
  parameter int TOF_MAX_MM = TOF_MAX_MM_DEF,
  parameter int ADC_BITS   = ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [1:0]  position,
  input  logic        sensor_kind,
  input  logic [11:0] raw_reading,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  slot_out,
  output logic [10:0] distance,
  output logic [3:0]  wall_bitmap,
  output logic        front_wall,
  output logic [10:0] cal_average,
  output logic        last_result,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cfg_t cfg;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_pop;
  logic cmd_empty;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset      <= '0;
      cfg.side_thr    <= SIDE_THR_RST;
      cfg.front_thr   <= FRONT_THR_RST;
      cfg.ir_gain     <= IR_GAIN_RST;
      cfg.ir_baseline <= IR_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        REG_OFFSET_LEFT, REG_OFFSET_FRONT_LEFT, REG_OFFSET_FRONT_RIGHT, REG_OFFSET_RIGHT:
          cfg.offset[cfg_index[1:0]] <= cfg_data[10:0];
        REG_SIDE_THRESHOLD:  cfg.side_thr    <= cfg_data[10:0];
        REG_FRONT_THRESHOLD: cfg.front_thr   <= cfg_data[10:0];
        REG_IR_GAIN:         cfg.ir_gain     <= cfg_data;
        REG_IR_BASELINE:     cfg.ir_baseline <= cfg_data[11:0];
      endcase
    end
  end

  wdc_front #(
    .POSITIONS  (POSITIONS),
    .IR_MAX_MM  (IR_MAX_MM),
    .TOF_MIN_MM (TOF_MIN_MM),
    .TOF_MAX_MM (TOF_MAX_MM),
    .ADC_BITS   (ADC_BITS)
  ) u_front (
    .accept      (push && !full),
    .action      (action),
    .position    (position),
    .sensor_kind (sensor_kind),
    .raw_reading (raw_reading),
    .ir_baseline (cfg.ir_baseline),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  wdc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (full),
    .empty (cmd_empty)
  );

  wdc_back #(
    .POSITIONS (POSITIONS),
    .IR_MIN_MM (IR_MIN_MM),
    .IR_MAX_MM (IR_MAX_MM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  wdc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_out),
    .full  (res_full),
    .empty (empty)
  );

  assign slot_out    = res_out.slot;
  assign distance    = res_out.distance;
  assign wall_bitmap = res_out.bitmap;
  assign front_wall  = res_out.front;
  assign cal_average = res_out.average;
  assign last_result = res_out.last;

  // the sequencer never loses a result to a full queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a command is only taken from a queue that holds one
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // the shared divider is never restarted while it runs
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    u_back.div_req.start |-> !u_back.div_busy)
    else $error("divider started while busy");

endmodule
